FILE: design/nfc_chk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfc_chk_pkg
// Types and constants shared by the response frame checker modules.
// ----------------------------------------------------------------------------
package nfc_chk_pkg;

   // Parser phase, one per field of the frame, plus the waiting and done states
   typedef enum logic [3:0] {
      PH_WAIT,
      PH_PRE0,
      PH_PRE1,
      PH_START,
      PH_LEN,
      PH_LCS,
      PH_IDENT,
      PH_CODE,
      PH_PAYLOAD,
      PH_DSUM,
      PH_DONE
   } phase_type;

   // Final frame status codes
   typedef enum logic [3:0] {
      ST_OK         = 4'd0,
      ST_PREAMBLE   = 4'd1,
      ST_START_CODE = 4'd2,
      ST_SHORT_LEN  = 4'd3,
      ST_LEN_SUM    = 4'd4,
      ST_IDENT      = 4'd5,
      ST_RESP_CODE  = 4'd6,
      ST_TOO_LONG   = 4'd7,
      ST_DATA_SUM   = 4'd8
   } status_type;

   // One result transaction
   typedef struct packed {
      logic       is_status;
      logic [7:0] data_byte;
      logic [7:0] data_index;
      status_type frame_status;
      logic [7:0] payload_length;
   } result_type;

   // Live configuration registers
   typedef struct packed {
      logic [7:0] expected_command;
      logic [7:0] payload_capacity;
   } cfg_type;

   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPECTED_COMMAND = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAYLOAD_CAPACITY = 2'd1;

   localparam logic [7:0] RST_EXPECTED_COMMAND = 8'd74;
   localparam logic [7:0] RST_PAYLOAD_CAPACITY = 8'd32;

   localparam logic [7:0] PREAMBLE_BYTE = 8'h00;
   localparam logic [7:0] START_CODE    = 8'hFF;
   localparam logic [7:0] FRAME_IDENT   = 8'hD5;
   localparam logic [7:0] MIN_LENGTH    = 8'd2;

   localparam int unsigned RSP_DATA_W = 32;

endpackage

FILE: design/nfc_response_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfc_response_frame_checker
// Checks a received reader-chip response frame byte by byte and emits its
// payload bytes and one final status transaction.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one received frame byte per transaction; req_tuser marks the
//            first byte of a frame and restarts the parser.
//   rsp_*  : payload byte transactions (rsp_tuser low) and one status
//            transaction per frame (rsp_tuser high), at the first error or
//            at the data checksum byte. Bytes after the status are dropped
//            until the next start byte.
//   csr_*  : register writes, index 0 expected command, index 1 payload
//            capacity; always ready, to be used while the block is idle.
// Timing:
//   One byte accepted every cycle while the queue has room; each result
//   is registered in a two-entry result queue before it appears on rsp_*,
//   and that queue sets the acceptance.
// Stall:
//   req_tready drops only when both queue entries hold untaken results.
// Reset:
//   parser waits for a start byte, queue empties, registers return to
//   command 74 and capacity 32.
// ----------------------------------------------------------------------------
module nfc_response_frame_checker
   import nfc_chk_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // byte stream in
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] rx_byte
   input  logic                  req_tuser,   // [0] frame_start
   // result stream out
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [7:0] data_byte, [15:8] data_index,
                                              // [19:16] frame_status,
                                              // [27:20] payload_length, [31:28] zero
   output logic                  rsp_tuser,   // [0] is_status
   // register write port
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [7:0]            csr_data
);

   cfg_type    cfg_ff, cfg_in;
   logic       req_accept;
   logic       res_valid;
   result_type res;
   result_type out_res;

   // register writes complete in the cycle they are offered
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_EXPECTED_COMMAND: cfg_in.expected_command = csr_data;
            CSR_PAYLOAD_CAPACITY: cfg_in.payload_capacity = csr_data;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_command <= RST_EXPECTED_COMMAND;
         cfg_ff.payload_capacity <= RST_PAYLOAD_CAPACITY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // a byte is taken whenever the queue has room for its possible result
   assign req_accept = req_tvalid && req_tready;

   nfc_chk_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .rx_byte     (req_tdata),
      .frame_start (req_tuser),
      .cfg         (cfg_ff),
      .res_valid   (res_valid),
      .res         (res)
   );

   nfc_chk_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .not_full  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_res)
   );

   // pack the result fields, lowest first
   assign rsp_tuser = out_res.is_status;
   assign rsp_tdata = {4'd0, out_res.payload_length, out_res.frame_status,
                       out_res.data_index, out_res.data_byte};

endmodule

FILE: design/nfc_chk_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfc_chk_parser
// Byte-wise frame parser: phase register, length, checksum and payload count.
// ----------------------------------------------------------------------------
module nfc_chk_parser
   import nfc_chk_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] rx_byte,
   input  logic       frame_start,
   input  cfg_type    cfg,
   output logic       res_valid,
   output result_type res
);

   phase_type  phase_ff, phase_in, phase_cur;
   logic [7:0] flen_ff, flen_in, flen_cur;
   logic [7:0] sum_ff, sum_in, sum_cur;
   logic [7:0] seen_ff, seen_in, seen_cur;
   logic [7:0] plen;
   logic [8:0] code_want;
   logic [7:0] seen_next;
   logic       fault;
   status_type fault_code;

   // restart on a start flag, otherwise continue from the stored state
   always_comb begin
      phase_cur = frame_start ? PH_PRE0 : phase_ff;
      flen_cur  = frame_start ? 8'd0 : flen_ff;
      sum_cur   = frame_start ? 8'd0 : sum_ff;
      seen_cur  = frame_start ? 8'd0 : seen_ff;
      plen      = (flen_cur >= MIN_LENGTH) ? (flen_cur - MIN_LENGTH) : 8'd0;
      code_want = {1'b0, cfg.expected_command} + 9'd1;
      seen_next = seen_cur + 8'd1;
   end

   // per-phase checks
   always_comb begin
      fault      = 1'b0;
      fault_code = ST_OK;
      case (phase_cur)
         PH_PRE0, PH_PRE1: begin
            fault      = (rx_byte != PREAMBLE_BYTE);
            fault_code = ST_PREAMBLE;
         end
         PH_START: begin
            fault      = (rx_byte != START_CODE);
            fault_code = ST_START_CODE;
         end
         PH_LEN: begin
            fault      = (rx_byte < MIN_LENGTH);
            fault_code = ST_SHORT_LEN;
         end
         PH_LCS: begin
            fault      = ((flen_cur + rx_byte) != 8'd0);
            fault_code = ST_LEN_SUM;
         end
         PH_IDENT: begin
            fault      = (rx_byte != FRAME_IDENT);
            fault_code = ST_IDENT;
         end
         PH_CODE: begin
            if ({1'b0, rx_byte} != code_want) begin
               fault      = 1'b1;
               fault_code = ST_RESP_CODE;
            end else if (plen > cfg.payload_capacity) begin
               fault      = 1'b1;
               fault_code = ST_TOO_LONG;
            end
         end
         PH_DSUM: begin
            fault      = ((sum_cur + rx_byte) != 8'd0);
            fault_code = ST_DATA_SUM;
         end
         default: begin
            fault      = 1'b0;
            fault_code = ST_OK;
         end
      endcase
   end

   // next state
   always_comb begin
      phase_in = phase_ff;
      flen_in  = flen_ff;
      sum_in   = sum_ff;
      seen_in  = seen_ff;
      if (accept) begin
         phase_in = phase_cur;
         flen_in  = flen_cur;
         sum_in   = sum_cur;
         seen_in  = seen_cur;
         if (fault) begin
            phase_in = PH_DONE;
         end else begin
            case (phase_cur)
               PH_PRE0:  phase_in = PH_PRE1;
               PH_PRE1:  phase_in = PH_START;
               PH_START: phase_in = PH_LEN;
               PH_LEN: begin
                  flen_in  = rx_byte;
                  phase_in = PH_LCS;
               end
               PH_LCS:   phase_in = PH_IDENT;
               PH_IDENT: begin
                  sum_in   = rx_byte;
                  phase_in = PH_CODE;
               end
               PH_CODE: begin
                  sum_in   = sum_cur + rx_byte;
                  seen_in  = 8'd0;
                  phase_in = (plen != 8'd0) ? PH_PAYLOAD : PH_DSUM;
               end
               PH_PAYLOAD: begin
                  sum_in  = sum_cur + rx_byte;
                  seen_in = seen_next;
                  if (seen_next >= plen) begin
                     phase_in = PH_DSUM;
                  end
               end
               PH_DSUM:  phase_in = PH_DONE;
               default:  phase_in = phase_cur;
            endcase
         end
      end
   end

   // result generation
   always_comb begin
      res_valid = 1'b0;
      res       = '0;
      if (accept) begin
         if (fault) begin
            res_valid        = 1'b1;
            res.is_status    = 1'b1;
            res.frame_status = fault_code;
         end else begin
            case (phase_cur)
               PH_PAYLOAD: begin
                  res_valid      = 1'b1;
                  res.data_byte  = rx_byte;
                  res.data_index = seen_cur;
               end
               PH_DSUM: begin
                  res_valid          = 1'b1;
                  res.is_status      = 1'b1;
                  res.frame_status   = ST_OK;
                  res.payload_length = plen;
               end
               default: res_valid = 1'b0;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         flen_ff  <= 8'd0;
         sum_ff   <= 8'd0;
         seen_ff  <= 8'd0;
      end else begin
         phase_ff <= phase_in;
         flen_ff  <= flen_in;
         sum_ff   <= sum_in;
         seen_ff  <= seen_in;
      end
   end

`ifndef SYNTHESIS
   a_status_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.is_status) |-> (phase_in == PH_DONE))
      else $error("status result without closing the frame");

   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && !frame_start && (phase_ff == PH_DONE || phase_ff == PH_WAIT))
      |-> !res_valid)
      else $error("result produced outside a frame");
`endif

endmodule

FILE: design/nfc_chk_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfc_chk_outq
// Two-entry result queue: registers each result and decouples the stall.
// ----------------------------------------------------------------------------
module nfc_chk_outq
   import nfc_chk_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       not_full,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   result_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != 2'd0);
   assign not_full  = (count_ff != 2'd2);
   assign out_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != 2'd2))
      else $error("result pushed into a full queue");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - 2'd1))
      else $error("queue occupancy lost track of a pop");
`endif

endmodule

FILE: dv/tb_nfc_response_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nfc_response_frame_checker
// Self-checking bench for the response frame checker: streams well-formed,
// damaged and cut-short frames mixed with stray bytes through the byte
// channel, predicts every payload and status transaction, and compares the
// result channel against that prediction under random or no back-pressure.
// ----------------------------------------------------------------------------
module tb_nfc_response_frame_checker;
   import nfc_chk_pkg::*;

   // Ways in which a generated frame is damaged
   typedef enum int {
      F_NONE,
      F_PRE0,
      F_PRE1,
      F_START,
      F_SHORT,
      F_LSUM,
      F_IDENT,
      F_CODE,
      F_DSUM,
      F_CUT
   } frame_fault_type;

   // One byte waiting to be sent, with its frame start flag
   typedef struct packed {
      logic [7:0] value;
      logic       first;
   } link_byte_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;   // [7:0] rx_byte
   logic                  req_tuser = 1'b0; // [0] frame_start
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // [7:0] data_byte, [15:8] data_index,
                                            // [19:16] frame_status,
                                            // [27:20] payload_length
   logic                  rsp_tuser;        // [0] is_status
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [7:0]            csr_data = '0;

   // Bytes still to be sent and results the parser copy has produced
   link_byte_type link_bytes_q[$];
   result_type    parser_results_q[$];

   // Parser copy: live state and register values
   phase_type  prs_phase = PH_WAIT;
   logic [7:0] prs_len   = '0;
   logic [7:0] prs_sum   = '0;
   logic [7:0] prs_count = '0;
   logic [7:0] cfg_cmd   = RST_EXPECTED_COMMAND;
   logic [7:0] cfg_cap   = RST_PAYLOAD_CAPACITY;

   int send_idle_pct = 23;
   int recv_idle_pct = 68;
   int fail_count    = 0;
   int bytes_queued  = 0;

   link_byte_type next_byte;
   result_type    predicted;
   result_type    seen;
   result_type    oldest;

   nfc_response_frame_checker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Advance the parser copy by one accepted byte; return 1 when a result follows
   function automatic bit parse_frame_byte(input logic [7:0] rx, input logic start,
                                           output result_type res);
      logic [7:0] body_len;
      logic [7:0] sum8;
      status_type st;
      bit         fin;
      bit         emit;
      res  = '0;
      st   = ST_OK;
      fin  = 1'b0;
      emit = 1'b0;
      if (start) begin
         prs_phase = PH_PRE0;
         prs_len   = '0;
         prs_sum   = '0;
         prs_count = '0;
      end
      body_len = (prs_len >= MIN_LENGTH) ? prs_len - MIN_LENGTH : 8'd0;
      case (prs_phase)
         PH_PRE0: begin
            if (rx != PREAMBLE_BYTE) begin
               fin = 1'b1;
               st  = ST_PREAMBLE;
            end else prs_phase = PH_PRE1;
         end
         PH_PRE1: begin
            if (rx != PREAMBLE_BYTE) begin
               fin = 1'b1;
               st  = ST_PREAMBLE;
            end else prs_phase = PH_START;
         end
         PH_START: begin
            if (rx != START_CODE) begin
               fin = 1'b1;
               st  = ST_START_CODE;
            end else prs_phase = PH_LEN;
         end
         PH_LEN: begin
            if (rx < MIN_LENGTH) begin
               fin = 1'b1;
               st  = ST_SHORT_LEN;
            end else begin
               prs_len   = rx;
               prs_phase = PH_LCS;
            end
         end
         PH_LCS: begin
            sum8 = prs_len + rx;
            if (sum8 != 8'd0) begin
               fin = 1'b1;
               st  = ST_LEN_SUM;
            end else prs_phase = PH_IDENT;
         end
         PH_IDENT: begin
            if (rx != FRAME_IDENT) begin
               fin = 1'b1;
               st  = ST_IDENT;
            end else begin
               prs_sum   = rx;
               prs_phase = PH_CODE;
            end
         end
         PH_CODE: begin
            // compare in 9 bits so that command 255 can never be answered
            if ({1'b0, rx} != {1'b0, cfg_cmd} + 9'd1) begin
               fin = 1'b1;
               st  = ST_RESP_CODE;
            end else begin
               prs_sum = prs_sum + rx;
               if (body_len > cfg_cap) begin
                  fin = 1'b1;
                  st  = ST_TOO_LONG;
               end else begin
                  prs_count = '0;
                  prs_phase = (body_len != 8'd0) ? PH_PAYLOAD : PH_DSUM;
               end
            end
         end
         PH_PAYLOAD: begin
            emit           = 1'b1;
            res.data_byte  = rx;
            res.data_index = prs_count;
            prs_sum        = prs_sum + rx;
            prs_count      = prs_count + 8'd1;
            if (prs_count >= body_len) prs_phase = PH_DSUM;
         end
         PH_DSUM: begin
            fin  = 1'b1;
            sum8 = prs_sum + rx;
            st   = (sum8 != 8'd0) ? ST_DATA_SUM : ST_OK;
         end
         default: ;
      endcase
      if (fin) begin
         res.is_status      = 1'b1;
         res.frame_status   = st;
         res.payload_length = (st == ST_OK) ? body_len : 8'd0;
         prs_phase          = PH_DONE;
      end
      return fin || emit;
   endfunction

   function automatic void check_field(input string field, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
         fail_count++;
      end
   endfunction

   // Driver: predict on every accepted byte, then offer the next one or idle
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (parse_frame_byte(req_tdata, req_tuser, predicted))
               parser_results_q.push_back(predicted);
         end
         // hold the current byte until it is taken
         if (!req_tvalid || req_tready) begin
            if (link_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_byte = link_bytes_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_byte.value;
               req_tuser  <= next_byte.first;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare every result transaction with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.is_status      = rsp_tuser;
            seen.data_byte      = rsp_tdata[7:0];
            seen.data_index     = rsp_tdata[15:8];
            seen.frame_status   = status_type'(rsp_tdata[19:16]);
            seen.payload_length = rsp_tdata[27:20];
            if (parser_results_q.size() == 0) begin
               $error("result transaction with none predicted: tuser %0b tdata %h",
                      rsp_tuser, rsp_tdata);
               fail_count++;
            end else begin
               oldest = parser_results_q.pop_front();
               check_field("is_status", oldest.is_status, seen.is_status);
               check_field("data_byte", oldest.data_byte, seen.data_byte);
               check_field("data_index", oldest.data_index, seen.data_index);
               check_field("frame_status", oldest.frame_status, seen.frame_status);
               check_field("payload_length", oldest.payload_length, seen.payload_length);
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic push_byte(input logic [7:0] value, input logic first);
      link_bytes_q.push_back('{value: value, first: first});
      bytes_queued++;
   endtask

   // Build a frame for the current command, damage it as asked, and queue it
   task automatic queue_frame(input int body_len, input frame_fault_type fault);
      logic [7:0] fb[$];
      logic [7:0] lenb;
      logic [7:0] code;
      logic [7:0] sum;
      logic [7:0] d;
      int         keep;
      lenb = 8'(body_len + 2);
      code = cfg_cmd + 8'd1;
      fb   = {PREAMBLE_BYTE, PREAMBLE_BYTE, START_CODE, lenb};
      d    = 8'd0 - lenb;
      fb.push_back(d);
      fb.push_back(FRAME_IDENT);
      fb.push_back(code);
      sum = FRAME_IDENT + code;
      for (int i = 0; i < body_len; i++) begin
         d = 8'($urandom);
         fb.push_back(d);
         sum = sum + d;
      end
      d = 8'd0 - sum;
      fb.push_back(d);
      case (fault)
         F_PRE0:  fb[0] = 8'($urandom_range(1, 255));
         F_PRE1:  fb[1] = 8'($urandom_range(1, 255));
         F_START: fb[2] = 8'($urandom_range(0, 254));
         F_SHORT: fb[3] = 8'($urandom_range(0, 1));
         F_LSUM:  fb[4] = fb[4] ^ 8'($urandom_range(1, 255));
         F_IDENT: fb[5] = fb[5] ^ 8'($urandom_range(1, 255));
         F_CODE:  fb[6] = fb[6] ^ 8'($urandom_range(1, 255));
         F_DSUM:  fb[fb.size()-1] = fb[fb.size()-1] ^ 8'($urandom_range(1, 255));
         F_CUT: begin
            // the next frame start then lands mid-frame
            keep = $urandom_range(1, fb.size() - 1);
            while (fb.size() > keep) void'(fb.pop_back());
         end
         default: ;
      endcase
      foreach (fb[i]) push_byte(fb[i], i == 0);
   endtask

   // Block until every byte is taken and every predicted result has arrived
   task automatic wait_quiet();
      do @(negedge clock);
      while (link_bytes_q.size() != 0 || req_tvalid || parser_results_q.size() != 0);
      // let a byte without a result clear the parser
      repeat (4) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_EXPECTED_COMMAND: cfg_cmd = value;
         CSR_PAYLOAD_CAPACITY: cfg_cap = value;
         default: ;
      endcase
   endtask

   task automatic run_random(input int target, input bit pause_midway);
      int              start_count;
      int              n;
      int              body_len;
      bit              paused;
      frame_fault_type fault;
      start_count = bytes_queued;
      paused      = 1'b0;
      while (bytes_queued - start_count < target) begin
         if ($urandom_range(9) == 0) begin
            // stray bytes, now and then with a start flag
            n = $urandom_range(1, 4);
            repeat (n) push_byte(8'($urandom), $urandom_range(7) == 0);
         end else begin
            body_len = ($urandom_range(39) == 0) ? $urandom_range(0, 253)
                                                 : $urandom_range(0, 12);
            fault = ($urandom_range(99) < 55) ? F_NONE
                                              : frame_fault_type'($urandom_range(1, F_CUT));
            queue_frame(body_len, fault);
         end
         if (pause_midway && !paused && bytes_queued - start_count >= target / 2) begin
            // starve the block until it has delivered everything
            wait_quiet();
            paused = 1'b1;
         end
      end
      wait_quiet();
   endtask

   initial begin
      logic [7:0] dsum;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: stray byte, then a frame whose registers change mid-frame
      push_byte(8'hA5, 1'b0);
      push_byte(PREAMBLE_BYTE, 1'b1);
      push_byte(PREAMBLE_BYTE, 1'b0);
      push_byte(START_CODE, 1'b0);
      push_byte(8'h03, 1'b0);
      push_byte(8'hFD, 1'b0);
      push_byte(FRAME_IDENT, 1'b0);
      wait_quiet();
      write_register(CSR_EXPECTED_COMMAND, 8'h10);
      write_register(CSR_PAYLOAD_CAPACITY, 8'h01);
      push_byte(8'h11, 1'b0);
      push_byte(8'hFF, 1'b0);
      dsum = 8'd0 - (FRAME_IDENT + 8'h11 + 8'hFF);
      push_byte(dsum, 1'b0);
      push_byte(8'h00, 1'b0);
      // empty payload, a start that cuts a frame short, then bad start code and short length
      queue_frame(0, F_NONE);
      push_byte(PREAMBLE_BYTE, 1'b1);
      push_byte(PREAMBLE_BYTE, 1'b0);
      push_byte(8'h01, 1'b1);
      push_byte(PREAMBLE_BYTE, 1'b1);
      push_byte(PREAMBLE_BYTE, 1'b0);
      push_byte(8'hFE, 1'b0);
      push_byte(PREAMBLE_BYTE, 1'b1);
      push_byte(PREAMBLE_BYTE, 1'b0);
      push_byte(START_CODE, 1'b0);
      push_byte(8'h01, 1'b0);
      wait_quiet();

      // Random phases, sender lightly idle and receiver heavily stalled
      write_register(CSR_EXPECTED_COMMAND, RST_EXPECTED_COMMAND);
      write_register(CSR_PAYLOAD_CAPACITY, RST_PAYLOAD_CAPACITY);
      run_random(220, 1'b0);
      write_register(CSR_EXPECTED_COMMAND, 8'hFF);
      write_register(CSR_PAYLOAD_CAPACITY, 8'h00);
      run_random(90, 1'b0);

      // Swap the idling of the two sides
      send_idle_pct = 68;
      recv_idle_pct = 23;
      write_register(CSR_EXPECTED_COMMAND, 8'h00);
      write_register(CSR_PAYLOAD_CAPACITY, 8'hFF);
      queue_frame(253, F_NONE);
      run_random(220, 1'b1);
      write_register(CSR_EXPECTED_COMMAND, 8'($urandom_range(0, 254)));
      write_register(CSR_PAYLOAD_CAPACITY, 8'($urandom_range(0, 16)));
      run_random(190, 1'b0);

      // No idling on either side
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_register(CSR_EXPECTED_COMMAND, 8'($urandom_range(0, 255)));
      write_register(CSR_PAYLOAD_CAPACITY, 8'($urandom_range(0, 12)));
      run_random(190, 1'b0);
      write_register(CSR_EXPECTED_COMMAND, 8'($urandom_range(0, 254)));
      write_register(CSR_PAYLOAD_CAPACITY, 8'($urandom_range(4, 255)));
      run_random(190, 1'b0);

      repeat (8) @(negedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Drop the run if it hangs
   initial begin
      #5000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
